// ===== src/rlpt_pkg.sv =====
// Package: shared types and codes for the rate-limited pattern trigger.
package rlpt_pkg;

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_TICK  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        OUT_NONE     = 2'd0,
        OUT_FIRED    = 2'd1,
        OUT_COOLDOWN = 2'd2,
        OUT_BURST    = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        REG_SLOTS_USED    = 3'd0,
        REG_SLOT_ENABLE   = 3'd1,
        REG_COOLDOWN      = 3'd2,
        REG_BURST_MAX     = 3'd3,
        REG_BURST_WINDOW  = 3'd4
    } reg_idx_t;

    localparam logic [15:0] COOLDOWN_RESET = 16'd2000;
    localparam logic [7:0]  BURST_MAX_RESET = 8'd20;
    localparam logic [15:0] WINDOW_RESET = 16'd10000;

    // Per-cycle control broadcast to every slot cell.
    typedef struct packed {
        logic       shift;     // a byte enters the history
        logic       clear;     // buffer cleared after a match
        logic [7:0] data;
    } cell_ctl_t;

endpackage

// ===== src/rlpt_hist_cell.sv =====
// History cell: one byte of the received-byte shift line.
module rlpt_hist_cell (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift,
    input  logic [7:0] prev_byte,
    output logic [7:0] cur_byte
);

    logic [7:0] byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else if (shift)
        begin
            byte_reg <= prev_byte;
        end
    end

    assign cur_byte = byte_reg;

endmodule

// ===== src/rlpt_slot_cell.sv =====
// Slot cell: one pattern slot, its pattern bytes and its match tracking.
module rlpt_slot_cell #(
    parameter int PAT_MAX   = 32,
    parameter int BUF_BYTES = 4096,
    parameter int AGE_W     = 13,
    parameter int LEN_W     = 7,
    parameter int POS_W     = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rlpt_pkg::cell_ctl_t        ctl,
    input  logic [PAT_MAX-1:0][7:0]    hist,      // hist[0] is the byte before the new one
    input  logic [AGE_W-1:0]           since_clear, // count before this byte
    input  logic                       wr_en,
    input  logic [POS_W-1:0]           wr_pos,
    input  logic                       wr_pos_ok,
    input  logic [LEN_W-1:0]           wr_len,
    output logic                       counts,    // nonempty and a match counts
    output logic                       nonempty
);

    logic [PAT_MAX-1:0][7:0] pat_reg;
    logic [LEN_W-1:0]        len_reg;
    logic                    seen_reg, seen_next;
    logic [AGE_W-1:0]        age_reg, age_next;
    logic                    seen_upd;
    logic [AGE_W-1:0]        age_upd;
    logic [PAT_MAX:0][7:0]   win;
    logic [PAT_MAX-1:0]      eq;
    logic                    hit;
    logic [AGE_W:0]          since_inc;

    // Window with the new byte at index 0.
    always_comb
    begin
        win[0] = ctl.data;
        for (int k = 0; k < PAT_MAX; k++)
        begin
            win[k+1] = hist[k];
        end
    end

    // Position p of the pattern compares with window byte len-1-p.
    always_comb
    begin
        for (int p = 0; p < PAT_MAX; p++)
        begin
            if (LEN_W'(p) < len_reg)
            begin
                eq[p] = (pat_reg[p] == win[len_reg - LEN_W'(p + 1)]);
            end
            else
            begin
                eq[p] = 1'b1;
            end
        end
    end

    assign since_inc = ({1'b0, since_clear} < (AGE_W+1)'(BUF_BYTES))
                     ? {1'b0, since_clear} + 1'b1 : {1'b0, since_clear};
    assign hit = (len_reg != '0) && (&eq)
              && ((AGE_W+1)'(len_reg) <= since_inc);

    // Match state once the byte is in, before any clear.
    always_comb
    begin
        seen_upd = seen_reg;
        age_upd  = age_reg;
        if (seen_reg && ({1'b0, age_reg} < (AGE_W+1)'(BUF_BYTES)))
        begin
            age_upd = age_reg + 1'b1;
        end
        if (hit)
        begin
            seen_upd = 1'b1;
            age_upd  = '0;
        end
    end

    always_comb
    begin
        seen_next = seen_reg;
        age_next  = age_reg;
        if (ctl.clear)
        begin
            seen_next = 1'b0;
            age_next  = '0;
        end
        else if (wr_en)
        begin
            seen_next = 1'b0;
            age_next  = '0;
        end
        else if (ctl.shift)
        begin
            seen_next = seen_upd;
            age_next  = age_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            seen_reg <= 1'b0;
            age_reg  <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
            age_reg  <= age_next;
            if (wr_en)
            begin
                len_reg <= wr_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && wr_pos_ok)
        begin
            pat_reg[wr_pos] <= ctl.data;
        end
    end

    // Combinational view of the match after this byte, used by a check.
    assign nonempty = (len_reg != '0);
    assign counts = nonempty && seen_upd
                 && ((AGE_W+1)'(age_upd) + (AGE_W+1)'(len_reg)
                     <= (AGE_W+1)'(BUF_BYTES));

endmodule

// ===== src/rate_limited_pattern_trigger.sv =====
// Top level: rate-limited pattern trigger with a chain of history and slot cells.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a
//   received byte (operation 0), a millisecond tick (1) or a pattern table
//   write (2). A received byte with chunk_end set, while the slot count is
//   nonzero, runs a check that yields exactly one result transfer on the
//   output channel (out_valid/out_ready); every other item yields none.
//   Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
//   always taken and are meant to be issued only while the block is idle.
//   Throughput: one input item per cycle while in_ready is high. Matching
//   is done by a row of slot cells comparing every pattern against the
//   history shift line in parallel; the check's priority pick, cooldown
//   and burst compare settle in the same cycle.
//   Output: a result is in the output register in the cycle after its
//   input transfer.
//   Stall: the output register holds the result; in_ready stays high as long
//   as the register is empty or being drained this cycle, so a stalled
//   receiver holds off only items once a result is waiting.
//   Reset: history, counters, lengths, fire marks and the window clear at
//   once; pattern bytes are undefined until written. Config takes its
//   documented reset values.
module rate_limited_pattern_trigger #(
    parameter int NUM_SLOTS = 8,
    parameter int PAT_MAX   = 32,
    parameter int BUF_BYTES = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [7:0] data_value,
    input  logic       chunk_end,
    input  logic [2:0] slot,
    input  logic [4:0] position,
    input  logic [5:0] pattern_length,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] outcome,
    output logic [2:0] trigger_slot,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AGE_W = $clog2(BUF_BYTES + 1);
    localparam int LEN_W = $clog2(PAT_MAX + 1);
    localparam int POS_W = (PAT_MAX > 1) ? $clog2(PAT_MAX) : 1;
    localparam int SL_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NS8   = (NUM_SLOTS < 8) ? NUM_SLOTS : 8;

    // Configuration registers.
    logic [3:0]  trig_cnt_reg;
    logic [7:0]  slot_en_reg;
    logic [15:0] cooldown_reg;
    logic [7:0]  burst_max_reg;
    logic [15:0] window_reg;

    // Timing state.
    logic [31:0] now_reg;
    logic [31:0] win_start_reg;
    logic        win_open_reg;
    logic [7:0]  burst_cnt_reg;
    logic [NUM_SLOTS-1:0][31:0] last_fire_reg;
    logic [NUM_SLOTS-1:0]       fired_reg;
    logic [AGE_W-1:0]           since_reg;

    // Output register.
    logic       ov_reg;
    logic [1:0] oc_reg;
    logic [2:0] os_reg;

    logic in_xfer;
    logic is_byte, take, do_check, do_write;
    rlpt_pkg::cell_ctl_t ctl;
    logic [PAT_MAX-1:0][7:0] hist;
    logic [NUM_SLOTS-1:0] counts, nonempty, cand;
    logic [3:0] used;
    logic found;
    logic [SL_W-1:0] pick;
    logic win_restart;
    logic [7:0] burst_eff;
    logic cool_block, burst_block;
    rlpt_pkg::outcome_t oc_next;
    logic [LEN_W-1:0] wr_len;
    logic [AGE_W-1:0] since_next;

    assign cfg_ready = 1'b1;
    assign in_ready  = !ov_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    assign is_byte  = (rlpt_pkg::op_t'(operation) == rlpt_pkg::OP_BYTE);
    assign take     = in_xfer && is_byte && (trig_cnt_reg != 4'd0);
    assign do_check = take && chunk_end;
    assign do_write = in_xfer && (rlpt_pkg::op_t'(operation) == rlpt_pkg::OP_WRITE)
                   && ({1'b0, slot} < 4'(NUM_SLOTS));
    assign wr_len   = (pattern_length > 6'(PAT_MAX)) ? LEN_W'(PAT_MAX)
                                                     : LEN_W'(pattern_length);

    // History shift line.
    for (genvar k = 0; k < PAT_MAX; k++)
    begin : g_hist
        rlpt_hist_cell u_h (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (take),
            .prev_byte((k == 0) ? data_value : hist[(k == 0) ? 0 : k-1]),
            .cur_byte (hist[k])
        );
    end

    assign ctl.shift = take;
    assign ctl.data  = data_value;
    assign ctl.clear = do_check && found;

    // Row of slot cells.
    for (genvar s = 0; s < NUM_SLOTS; s++)
    begin : g_slot
        rlpt_slot_cell #(
            .PAT_MAX  (PAT_MAX),
            .BUF_BYTES(BUF_BYTES),
            .AGE_W    (AGE_W),
            .LEN_W    (LEN_W),
            .POS_W    (POS_W)
        ) u_s (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .hist       (hist),
            .since_clear(since_reg),
            .wr_en      (do_write && (slot == 3'(s))),
            .wr_pos     (POS_W'(position)),
            .wr_pos_ok  ({1'b0, position} < 6'(PAT_MAX)),
            .wr_len     (wr_len),
            .counts     (counts[s]),
            .nonempty   (nonempty[s])
        );
    end

    // Candidate slots: below the slot count, enabled, with a counting match.
    assign used = (trig_cnt_reg > 4'(NS8)) ? 4'(NS8) : trig_cnt_reg;
    always_comb
    begin
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            if (s < 8)
            begin
                cand[s] = (4'(s) < used) && slot_en_reg[s] && nonempty[s] && counts[s];
            end
            else
            begin
                cand[s] = 1'b0;
            end
        end
    end

    // Lowest-numbered candidate.
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (cand[s])
            begin
                found = 1'b1;
                pick  = SL_W'(s);
            end
        end
    end

    assign win_restart = !win_open_reg || ((now_reg - win_start_reg) > {16'd0, window_reg});
    assign burst_eff   = win_restart ? 8'd0 : burst_cnt_reg;
    assign cool_block  = fired_reg[pick]
                      && ((now_reg - last_fire_reg[pick]) < {16'd0, cooldown_reg});
    assign burst_block = (burst_eff >= burst_max_reg);

    always_comb
    begin
        priority if (!found)
        begin
            oc_next = rlpt_pkg::OUT_NONE;
        end
        else if (cool_block)
        begin
            oc_next = rlpt_pkg::OUT_COOLDOWN;
        end
        else if (burst_block)
        begin
            oc_next = rlpt_pkg::OUT_BURST;
        end
        else
        begin
            oc_next = rlpt_pkg::OUT_FIRED;
        end
    end

    always_comb
    begin
        since_next = since_reg;
        if (ctl.clear)
        begin
            since_next = '0;
        end
        else if (take && ({1'b0, since_reg} < (AGE_W+1)'(BUF_BYTES)))
        begin
            since_next = since_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_cnt_reg  <= '0;
            slot_en_reg   <= '0;
            cooldown_reg  <= rlpt_pkg::COOLDOWN_RESET;
            burst_max_reg <= rlpt_pkg::BURST_MAX_RESET;
            window_reg    <= rlpt_pkg::WINDOW_RESET;
            now_reg       <= '0;
            win_start_reg <= '0;
            win_open_reg  <= 1'b0;
            burst_cnt_reg <= '0;
            last_fire_reg <= '0;
            fired_reg     <= '0;
            since_reg     <= '0;
            ov_reg        <= 1'b0;
            oc_reg        <= '0;
            os_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (rlpt_pkg::reg_idx_t'(cfg_index))
                    rlpt_pkg::REG_SLOTS_USED:    trig_cnt_reg  <= cfg_data[3:0];
                    rlpt_pkg::REG_SLOT_ENABLE:   slot_en_reg   <= cfg_data[7:0];
                    rlpt_pkg::REG_COOLDOWN:      cooldown_reg  <= cfg_data;
                    rlpt_pkg::REG_BURST_MAX:     burst_max_reg <= cfg_data[7:0];
                    rlpt_pkg::REG_BURST_WINDOW:  window_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (in_xfer && (rlpt_pkg::op_t'(operation) == rlpt_pkg::OP_TICK))
            begin
                now_reg <= now_reg + 32'd1;
            end
            since_reg <= since_next;
            if (do_check)
            begin
                win_open_reg <= 1'b1;
                if (win_restart)
                begin
                    win_start_reg <= now_reg;
                end
                if (oc_next == rlpt_pkg::OUT_FIRED)
                begin
                    last_fire_reg[pick] <= now_reg;
                    fired_reg[pick]     <= 1'b1;
                    burst_cnt_reg <= (burst_eff != 8'hFF) ? burst_eff + 8'd1 : burst_eff;
                end
                else
                begin
                    burst_cnt_reg <= burst_eff;
                end
            end
            if (do_check)
            begin
                ov_reg <= 1'b1;
                oc_reg <= oc_next;
                os_reg <= found ? 3'(pick) : 3'd0;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = ov_reg;
    assign outcome      = oc_reg;
    assign trigger_slot = os_reg;

    // A check never overwrites an undelivered result.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |-> !in_xfer)
        else $error("result overwritten");

    // No-match results always report slot zero.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oc_reg == rlpt_pkg::OUT_NONE) |-> (os_reg == 3'd0))
        else $error("slot on no match");

    // A fire marks the slot and opens the window.
    a_fire_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (do_check && oc_next == rlpt_pkg::OUT_FIRED)
        |=> (win_open_reg && fired_reg[$past(pick)]))
        else $error("fire not recorded");

    // A found match clears the byte count.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (do_check && found) |=> (since_reg == '0))
        else $error("buffer not cleared");

endmodule
